// ===== hw/rtl/rggp_pkg.sv =====
// radial gaussian gradient pixel: shared constants and the fade table function
// no dependencies
package rggp_pkg;

	localparam int TOP_LEVEL_DEF     = 8;
	localparam int FRACTION_BITS_DEF = 10;
	localparam logic [7:0] SHARP_RESET  = 8'd128;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam longint unsigned ONE_Q32 = 64'h1_0000_0000;
	localparam longint unsigned EXP_M1_Q32 = 64'd1580030169;

	// q.32 product, floored
	function automatic longint unsigned mul_q32(input longint unsigned a,
			input longint unsigned b);
		mul_q32 = (a * b) >> 32;
	endfunction

	// gray level for fraction fq in q0.fb, evaluated at elaboration only
	function automatic logic [7:0] fade_entry(input int unsigned fq, input int unsigned fb);
		longint unsigned sq, x, n, r, term, v, g;
		longint acc;
		begin
			if (fq == 0) begin
				fade_entry = 8'd255;
			end else if (fq >= (32'd1 << fb)) begin
				fade_entry = 8'd0;
			end else begin
				sq = (longint'(fq) * longint'(fq)) << (32 - 2 * fb);
				x = sq * 64'd50 / 64'd9;
				n = x >> 32;
				r = x & 64'hFFFF_FFFF;
				acc = longint'(ONE_Q32);
				// taylor terms of exp(-r), odd terms subtract
				term = mul_q32(ONE_Q32, r);
				acc = acc - longint'(term);
				term = mul_q32(term, r) / 64'd2;
				acc = acc + longint'(term);
				term = mul_q32(term, r) / 64'd3;
				acc = acc - longint'(term);
				term = mul_q32(term, r) / 64'd4;
				acc = acc + longint'(term);
				term = mul_q32(term, r) / 64'd5;
				acc = acc - longint'(term);
				term = mul_q32(term, r) / 64'd6;
				acc = acc + longint'(term);
				term = mul_q32(term, r) / 64'd7;
				acc = acc - longint'(term);
				term = mul_q32(term, r) / 64'd8;
				acc = acc + longint'(term);
				term = mul_q32(term, r) / 64'd9;
				acc = acc - longint'(term);
				term = mul_q32(term, r) / 64'd10;
				acc = acc + longint'(term);
				term = mul_q32(term, r) / 64'd11;
				acc = acc - longint'(term);
				term = mul_q32(term, r) / 64'd12;
				acc = acc + longint'(term);
				term = mul_q32(term, r) / 64'd13;
				acc = acc - longint'(term);
				if (acc < 0) acc = 0;
				if (acc > longint'(ONE_Q32)) acc = longint'(ONE_Q32);
				v = longint'(acc);
				for (longint unsigned i = 0; i < n; i++) begin
					v = (v * EXP_M1_Q32) >> 32;
				end
				g = (v * 64'd255) >> 32;
				if (g > 64'd255) g = 64'd255;
				fade_entry = g[7:0];
			end
		end
	endfunction

endpackage

// ===== hw/rtl/rggp_front.sv =====
// front end: level clamp, half-pixel offsets, radius terms, sum of squares
// no package dependencies
module rggp_front #(
	parameter int TOP = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic [3:0]           mip_level,
	input  logic [7:0]           row,
	input  logic [7:0]           column,
	input  logic [7:0]           sharp,
	output logic                 out_valid,
	output logic [2*TOP+1:0]     sumsq,
	output logic [TOP+11:0]      base,
	output logic [TOP+11:0]      den
);
	localparam int LW = (TOP < 2) ? 1 : $clog2(TOP + 1);
	localparam int BW = TOP + 12;

	logic [3:0]        lvl;
	logic [LW-1:0]     shamt;
	logic [TOP:0]      side;
	logic [TOP-1:0]    mask, rc, cc;
	logic [15:0]       row16, col16;
	logic signed [TOP+1:0] dx, dy;
	logic [11:0]       s9, w9;
	logic [8:0]        inv;

	always_comb begin
		lvl   = (mip_level > 4'(TOP)) ? 4'(TOP) : mip_level;
		shamt = LW'(TOP) - LW'(lvl);
		side  = (TOP+1)'(1) << shamt;
		mask  = TOP'(side - (TOP+1)'(1));
		row16 = 16'(row);
		col16 = 16'(column);
		rc    = row16[TOP-1:0] & mask;
		cc    = col16[TOP-1:0] & mask;
		dx    = $signed({1'b0, rc, 1'b0}) - $signed({1'b0, side});
		dy    = $signed({1'b0, cc, 1'b0}) - $signed({1'b0, side});
		s9    = 12'({4'b0, sharp} * 12'd9);
		inv   = 9'd256 - {1'b0, sharp};
		w9    = 12'({3'b0, inv} * 12'd9);
	end

	logic                  v_s1, v_s2;
	logic signed [TOP+1:0] dx_s1, dy_s1;
	logic [BW-1:0]         base_s1, den_s1, base_s2, den_s2;
	logic [2*TOP+1:0]      sum_s2;
	logic signed [2*TOP+3:0] sqx, sqy, sqs;

	always_comb begin
		sqx = dx_s1 * dx_s1;
		sqy = dy_s1 * dy_s1;
		sqs = sqx + sqy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1   <= dx;
			dy_s1   <= dy;
			base_s1 <= BW'(s9) << shamt;
			den_s1  <= BW'(w9) << shamt;
			sum_s2  <= sqs[2*TOP+1:0];
			base_s2 <= base_s1;
			den_s2  <= den_s1;
		end
	end

	assign out_valid = v_s2;
	assign sumsq     = sum_s2;
	assign base      = base_s2;
	assign den       = den_s2;

endmodule

// ===== hw/rtl/rggp_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// no package dependencies
module rggp_sqrt #(
	parameter int RB = 17,
	parameter int CW = 40
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  logic [2*RB-1:0] rad,
	input  logic [CW-1:0]   in_carry,
	output logic            out_valid,
	output logic [RB-1:0]   root,
	output logic [CW-1:0]   out_carry
);
	localparam int RW = RB + 2;

	logic            valid_s [RB+1];
	logic [2*RB-1:0] rad_s   [RB+1];
	logic [RB-1:0]   root_s  [RB+1];
	logic [RW-1:0]   rem_s   [RB+1];
	logic [CW-1:0]   carry_s [RB+1];

	assign valid_s[0] = in_valid;
	assign rad_s[0]   = rad;
	assign root_s[0]  = '0;
	assign rem_s[0]   = '0;
	assign carry_s[0] = in_carry;

	for (genvar i = 0; i < RB; i++) begin : g_stage
		logic [RW-1:0] cur, sub, trial;
		logic          ge;
		always_comb begin
			cur   = {rem_s[i][RB-1:0], rad_s[i][2*RB-1 -: 2]};
			sub   = {root_s[i], 2'b01};
			ge    = cur >= sub;
			trial = cur - sub;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (adv) begin
				valid_s[i+1] <= valid_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rad_s[i+1]   <= rad_s[i] << 2;
				root_s[i+1]  <= {root_s[i][RB-2:0], ge};
				rem_s[i+1]   <= ge ? trial : cur;
				carry_s[i+1] <= carry_s[i];
			end
		end
	end

	assign out_valid = valid_s[RB];
	assign root      = root_s[RB];
	assign out_carry = carry_s[RB];

`ifndef SYNTHESIS
	// remainder of an exact floor root never exceeds twice the root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[RB] |-> rem_s[RB] <= {1'b0, root_s[RB], 1'b0})
		else $error("sqrt remainder out of range");
`endif

endmodule

// ===== hw/rtl/rggp_div.sv =====
// fraction stage: numerator set-up then restoring division, one quotient bit per stage
// no package dependencies
module rggp_div #(
	parameter int RB = 17,
	parameter int DW = 20,
	parameter int F  = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  logic [RB-1:0] dq,
	input  logic [DW-1:0] base,
	input  logic [DW-1:0] den,
	output logic          out_valid,
	output logic [F-1:0]  q,
	output logic          sat
);
	localparam int NW = RB + 5;

	logic [RB+3:0] ten;
	logic [NW-1:0] diff;
	logic          nonpos, over;

	always_comb begin
		ten    = {1'b0, dq, 3'b0} + {3'b0, dq, 1'b0};
		diff   = {1'b0, ten} - NW'(base);
		nonpos = diff[NW-1] || (diff == '0);
		over   = !nonpos && (diff >= NW'(den));
	end

	logic          valid_s [F+1];
	logic [DW-1:0] rem_s   [F+1];
	logic [DW-1:0] den_s   [F+1];
	logic [F-1:0]  q_s     [F+1];
	logic          sat_s   [F+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= (nonpos || over) ? '0 : diff[DW-1:0];
			den_s[0] <= den;
			q_s[0]   <= '0;
			sat_s[0] <= over;
		end
	end

	for (genvar j = 0; j < F; j++) begin : g_step
		logic [DW:0] dbl, dsub;
		logic        ge;
		always_comb begin
			dbl  = {rem_s[j], 1'b0};
			ge   = dbl >= {1'b0, den_s[j]};
			dsub = dbl - {1'b0, den_s[j]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else if (adv) begin
				valid_s[j+1] <= valid_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j+1] <= ge ? dsub[DW-1:0] : dbl[DW-1:0];
				den_s[j+1] <= den_s[j];
				q_s[j+1]   <= (F == 1) ? F'(ge) : {q_s[j][F-2:0], ge};
				sat_s[j+1] <= sat_s[j];
			end
		end
	end

	assign out_valid = valid_s[F];
	assign q         = q_s[F];
	assign sat       = sat_s[F];

`ifndef SYNTHESIS
	// remainder stays below the divisor through the chain
	a_rem_lt_den: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[F] |-> (rem_s[F] < den_s[F]) || (den_s[F] == '0))
		else $error("division remainder not below divisor");
	// a saturated fraction carries an empty quotient
	a_sat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[F] && sat_s[F]) |-> (q_s[F] == '0))
		else $error("saturated fraction with non-zero quotient");
`endif

endmodule

// ===== hw/rtl/rggp_fade.sv =====
// fade table lookup with registered read, doubles as the output register
// depends on rggp_pkg for the table contents
module rggp_fade #(
	parameter int F = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         in_valid,
	input  logic [F-1:0] q,
	input  logic         sat,
	output logic         out_valid,
	output logic [7:0]   gray
);
	import rggp_pkg::*;

	localparam int DEPTH = 1 << F;

	logic [7:0] rom [DEPTH];
	for (genvar i = 0; i < DEPTH; i++) begin : g_rom
		assign rom[i] = fade_entry(32'(i), 32'(F));
	end

	logic       valid_q;
	logic [7:0] gray_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gray_q <= sat ? 8'd0 : rom[q];
		end
	end

	assign out_valid = valid_q;
	assign gray      = gray_q;

endmodule

// ===== hw/rtl/radial_gaussian_gradient_pixel.sv =====
// radial gaussian gradient texel pipeline, one pixel transaction per cycle unless a waiting result is stalled
// stages in order: 2 front, one per root bit,
// one set-up plus one per fraction bit in the divider, one table read
// the whole pipeline advances together and holds only while a result waits under stall
// arst_n clears all valid bits and loads sharpness with 128
module radial_gaussian_gradient_pixel #(
	parameter int TOP_LEVEL     = rggp_pkg::TOP_LEVEL_DEF,
	parameter int FRACTION_BITS = rggp_pkg::FRACTION_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] sharpness,
	input  logic       pix_valid,
	output logic       pix_stall,
	input  logic [3:0] mip_level,
	input  logic [7:0] row,
	input  logic [7:0] column,
	output logic       texel_valid,
	input  logic       texel_stall,
	output logic [7:0] gray,
	output logic [7:0] alpha
);
	import rggp_pkg::*;

	localparam int RB = TOP_LEVEL + 9;
	localparam int BW = TOP_LEVEL + 12;

	logic [7:0] sharp_q;
	logic       adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sharp_q <= SHARP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sharp_q <= sharpness;
		end
	end

	assign cfg_ready = 1'b1;
	assign adv       = !texel_valid || !texel_stall;
	assign pix_stall = !adv;

	logic                   fe_valid;
	logic [2*TOP_LEVEL+1:0] fe_sum;
	logic [BW-1:0]          fe_base, fe_den;

	rggp_front #(.TOP(TOP_LEVEL)) u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(pix_valid), .mip_level(mip_level), .row(row), .column(column),
		.sharp(sharp_q),
		.out_valid(fe_valid), .sumsq(fe_sum), .base(fe_base), .den(fe_den)
	);

	logic          sq_valid;
	logic [RB-1:0] sq_root;
	logic [2*BW-1:0] sq_carry;

	rggp_sqrt #(.RB(RB), .CW(2*BW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(fe_valid), .rad({fe_sum, 16'b0}), .in_carry({fe_base, fe_den}),
		.out_valid(sq_valid), .root(sq_root), .out_carry(sq_carry)
	);

	logic                     dv_valid, dv_sat;
	logic [FRACTION_BITS-1:0] dv_q;

	rggp_div #(.RB(RB), .DW(BW), .F(FRACTION_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(sq_valid), .dq(sq_root),
		.base(sq_carry[2*BW-1:BW]), .den(sq_carry[BW-1:0]),
		.out_valid(dv_valid), .q(dv_q), .sat(dv_sat)
	);

	rggp_fade #(.F(FRACTION_BITS)) u_fade (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(dv_valid), .q(dv_q), .sat(dv_sat),
		.out_valid(texel_valid), .gray(gray)
	);

	assign alpha = ALPHA_OPAQUE;

endmodule
